// ===== sv/utsd_pkg.sv =====
// Package for the UTF-8 to UCS-2 stream decoder.
// Holds the result status codes, the decoder modes and the queue entry type.
// No dependencies; every other file imports it.
package utsd_pkg;

  // Status of one result beat.
  typedef enum logic [1:0] {
    ST_CHAR  = 2'd0,
    ST_END   = 2'd1,
    ST_ABORT = 2'd2
  } status_t;

  // Decoder modes, one-hot.
  typedef enum logic [3:0] {
    MODE_LEAD    = 4'b0001,
    MODE_COLLECT = 4'b0010,
    MODE_SKIP    = 4'b0100,
    MODE_DISCARD = 4'b1000
  } mode_t;

  // Byte class thresholds.
  localparam logic [7:0] ASCII_LIMIT  = 8'h80;
  localparam logic [7:0] LEAD2_MAX    = 8'hdf;
  localparam logic [7:0] LEAD3_MAX    = 8'hef;
  localparam logic [7:0] LEAD4_MAX    = 8'hf7;
  localparam logic [7:0] LEAD5_MAX    = 8'hfb;
  localparam logic [7:0] LEAD6_MAX    = 8'hfd;

  // Queue between the decoder and the result sequencer.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // One queue entry: an optional character followed by an optional status.
  typedef struct packed {
    logic        has_char;
    logic [15:0] code_point;
    logic        has_stat;
    status_t     stat;
  } entry_t;

endpackage

// ===== sv/utsd_ifs.sv =====
// Stream interfaces of the UTF-8 to UCS-2 stream decoder.
// Byte channel in, result channel out; both valid/ready.
// Depends on utsd_pkg for the status type.
interface utsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface utsd_result_if
  import utsd_pkg::*;
;
  logic        valid;
  logic        ready;
  logic [15:0] code_point;
  status_t     status;
  logic        run_last;

  modport source (output valid, output code_point, output status, output run_last,
                  input ready);
  modport sink   (input valid, input code_point, input status, input run_last,
                  output ready);
endinterface

// ===== sv/utsd_front.sv =====
// Front part of the decoder: accepts bytes, tracks the UTF-8 sequence state
// and pushes one queue entry for every byte that causes results.
// Depends on utsd_pkg and utsd_byte_if.
module utsd_front
  import utsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  utsd_byte_if.sink         bytes,
  input  logic              q_full,
  output logic              q_push,
  output entry_t            q_data
);

  mode_t       mode, mode_next;
  logic [11:0] collected_bits, collected_bits_next;
  logic [2:0]  bytes_pending, bytes_pending_next;
  logic        accept;
  logic [7:0]  b;
  logic        last;
  entry_t      ent;

  assign bytes.ready = !q_full;
  assign accept      = bytes.valid && bytes.ready;
  assign b           = bytes.data_byte;
  assign last        = bytes.stream_end;

  // Next-state and result decode for the byte at the port.
  always_comb begin
    mode_next           = mode;
    collected_bits_next = collected_bits;
    bytes_pending_next  = bytes_pending;
    ent.has_char        = 1'b0;
    ent.code_point      = '0;
    ent.has_stat        = 1'b0;
    ent.stat            = ST_END;
    unique case (mode)
      MODE_LEAD: begin
        if (b < ASCII_LIMIT) begin
          ent.has_char   = 1'b1;
          ent.code_point = {8'h00, b};
        end else if (b <= LEAD2_MAX) begin
          collected_bits_next = {7'b0, b[4:0]};
          bytes_pending_next  = 3'd1;
          mode_next           = MODE_COLLECT;
        end else if (b <= LEAD3_MAX) begin
          collected_bits_next = {8'b0, b[3:0]};
          bytes_pending_next  = 3'd2;
          mode_next           = MODE_COLLECT;
        end else if (b <= LEAD4_MAX) begin
          bytes_pending_next = 3'd3;
          mode_next          = MODE_SKIP;
        end else if (b <= LEAD5_MAX) begin
          bytes_pending_next = 3'd4;
          mode_next          = MODE_SKIP;
        end else if (b <= LEAD6_MAX) begin
          bytes_pending_next = 3'd5;
          mode_next          = MODE_SKIP;
        end else begin
          ent.has_stat        = 1'b1;
          ent.stat            = ST_ABORT;
          collected_bits_next = '0;
          bytes_pending_next  = '0;
          mode_next           = last ? MODE_LEAD : MODE_DISCARD;
        end
      end
      MODE_COLLECT: begin
        if (bytes_pending <= 3'd1) begin
          ent.has_char        = 1'b1;
          ent.code_point      = {collected_bits[9:0], b[5:0]};
          collected_bits_next = '0;
          bytes_pending_next  = '0;
          mode_next           = MODE_LEAD;
        end else begin
          collected_bits_next = {collected_bits[5:0], b[5:0]};
          bytes_pending_next  = bytes_pending - 3'd1;
        end
      end
      MODE_SKIP: begin
        if (bytes_pending <= 3'd1) begin
          bytes_pending_next = '0;
          mode_next          = MODE_LEAD;
        end else begin
          bytes_pending_next = bytes_pending - 3'd1;
        end
      end
      MODE_DISCARD: begin
        if (last) begin
          mode_next = MODE_LEAD;
        end
      end
      default: begin
        mode_next = MODE_LEAD;
      end
    endcase

    // A clean stream end closes the stream, except after an abort.
    if (last && !ent.has_stat && mode != MODE_DISCARD) begin
      ent.has_stat        = 1'b1;
      ent.stat            = ST_END;
      collected_bits_next = '0;
      bytes_pending_next  = '0;
      mode_next           = MODE_LEAD;
    end
  end

  assign q_push = accept && (ent.has_char || ent.has_stat);
  assign q_data = ent;

  // Decoder state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_LEAD;
      collected_bits <= '0;
      bytes_pending  <= '0;
    end else if (accept) begin
      mode           <= mode_next;
      collected_bits <= collected_bits_next;
      bytes_pending  <= bytes_pending_next;
    end
  end

  // A sequence in progress always has bytes left to take.
  a_pending_nonzero: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_COLLECT || mode == MODE_SKIP) |-> bytes_pending != 3'd0)
    else $error("utsd_front: sequence mode with no pending bytes");

  // Nothing is pushed while the queue is full.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("utsd_front: push into a full queue");

endmodule

// ===== sv/utsd_fifo.sv =====
// Short queue of decoded entries between the decoder and the result sequencer.
// Register array with read and write pointers and an occupancy count.
// Depends on utsd_pkg.
module utsd_fifo
  import utsd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_data,
  output logic   full,
  input  logic   pop,
  output entry_t rd_data,
  output logic   empty
);

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Occupancy never exceeds the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("utsd_fifo: count beyond depth");

  // No pop from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("utsd_fifo: pop from an empty queue");

endmodule

// ===== sv/utsd_back.sv =====
// Back part of the decoder: takes queue entries and sends their results,
// the character first and then the status, one beat each.
// Depends on utsd_pkg and utsd_result_if.
module utsd_back
  import utsd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  entry_t        q_data,
  output logic          q_pop,
  utsd_result_if.source results
);

  entry_t cur;
  logic   cur_valid;
  logic   char_done;
  logic   show_char;
  logic   beat;
  logic   finish;

  // Output view of the held entry.
  assign show_char          = cur.has_char && !char_done;
  assign results.valid      = cur_valid;
  assign results.code_point = show_char ? cur.code_point : 16'h0000;
  assign results.status     = show_char ? ST_CHAR : cur.stat;
  assign results.run_last   = !show_char;

  // An entry is done on the beat of its last result.
  assign beat   = cur_valid && results.ready;
  assign finish = beat && !(show_char && cur.has_stat);
  assign q_pop  = (!cur_valid || finish) && !q_empty;

  // Output holding register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      char_done <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      char_done <= 1'b0;
    end else if (finish) begin
      cur_valid <= 1'b0;
      char_done <= 1'b0;
    end else if (beat) begin
      char_done <= 1'b1;
    end
  end

  // A character beat is never the last of the stream.
  a_char_not_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status == ST_CHAR) |-> !results.run_last)
    else $error("utsd_back: character beat marked last");

  // Status beats carry a zero code point and close the stream.
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status != ST_CHAR)
      |-> (results.run_last && results.code_point == 16'h0000))
    else $error("utsd_back: malformed status beat");

  // The character is marked sent only while its status is still owed.
  a_char_done: assert property (@(posedge clk) disable iff (rst)
    char_done |-> (cur_valid && cur.has_stat))
    else $error("utsd_back: stray character-sent flag");

endmodule

// ===== sv/utf8_to_ucs2_stream_decoder.sv =====
// Top level of the UTF-8 to UCS-2 stream decoder.
//
//   Channel   Role  Beat payload                        Accepted when
//   bytes     sink  data_byte[7:0], stream_end          valid && ready
//   results   src   code_point[15:0], status, run_last  valid && ready
//
// A byte is accepted every cycle while the four-entry queue has room.
// A byte is decoded in its beat cycle and queued at that edge; its first result
// passes through the queue and then the output holding register before it is
// valid. Results go out one beat per cycle while the results side is ready.
// A stall on the results side backs up the queue and only then drops ready.
// Synchronous reset returns the decoder to lead-byte mode and empties the queue.
//
// Depends on utsd_pkg, utsd_ifs, utsd_front, utsd_fifo and utsd_back.
module utf8_to_ucs2_stream_decoder
  import utsd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  utsd_byte_if.sink     bytes,
  utsd_result_if.source results
);

  logic   q_full;
  logic   q_empty;
  logic   q_push;
  logic   q_pop;
  entry_t q_wr_data;
  entry_t q_rd_data;

  // Byte decoder.
  utsd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  // Entry queue.
  utsd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // Result sequencer.
  utsd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule
